FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/mlc_pkg.sv
package mlc_pkg;

    localparam int unsigned MLC_CH_W    = 8;
    localparam int unsigned MLC_LEVEL_W = 2;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [2:0] POS_MAX    = 3'd7;
    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [2:0] STAR_SAT   = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BULLET,
        KIND_DIGIT,
        KIND_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        NUM_DIGITS,
        NUM_PUNCT,
        NUM_MATCH,
        NUM_FAIL
    } t_num_phase;

    typedef struct packed {
        logic [MLC_CH_W-1:0] ch;
        logic                end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [MLC_LEVEL_W-1:0] level;
        logic                   bullet_line;
        logic                   number_line;
        logic                   is_todo;
        logic                   is_done;
        logic                   detected;
    } t_result;

    // handoff from the input register to the scanner
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_in_slot;

    function automatic logic [7:0] f_todo_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h54;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h44;
            3'd3:    c = 8'h4F;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_done_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h44;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h45;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic f_is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

FILE: hdl/mlc_if.sv
interface mlc_in_if;
    import mlc_pkg::*;

    logic                valid;
    logic                ready;
    logic [MLC_CH_W-1:0] ch;
    logic                end_of_line;

    modport source (output valid, output ch, output end_of_line, input ready);
    modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface mlc_out_if;
    import mlc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [MLC_LEVEL_W-1:0] level;
    logic                   bullet_line;
    logic                   number_line;
    logic                   is_todo;
    logic                   is_done;
    logic                   detected;

    modport source (
        output valid, output level, output bullet_line, output number_line,
        output is_todo, output is_done, output detected, input ready
    );
    modport sink (
        input valid, input level, input bullet_line, input number_line,
        input is_todo, input is_done, input detected, output ready
    );
endinterface

FILE: hdl/mlc_in_stage.sv
module mlc_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mlc_in_if.sink           i_in,
    input  logic             i_take,
    output mlc_pkg::t_in_slot o_slot
);
    import mlc_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.ch          <= i_in.ch;
            r_item.end_of_line <= i_in.end_of_line;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.item  = r_item;
endmodule

FILE: hdl/mlc_scan.sv
module mlc_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlc_pkg::t_in_slot i_slot,
    input  logic              i_res_ready,
    output logic              o_take,
    output logic              o_res_valid,
    output mlc_pkg::t_result  o_res
);
    import mlc_pkg::*;

    logic       r_skipping, n_skipping;
    logic [2:0] r_position, n_position;
    logic [2:0] r_star, n_star;
    logic       r_header, n_header;
    t_kind      r_kind, n_kind;
    logic       r_todo, n_todo;
    logic       r_done, n_done;
    t_num_phase r_phase, n_phase;
    logic       r_bullet, n_bullet;
    logic       r_term, n_term;

    logic [7:0] w_c;
    logic       w_eol;
    logic       w_byte;
    t_result    w_res;

    assign w_c   = i_slot.item.ch;
    assign w_eol = i_slot.item.end_of_line;

    assign o_take      = i_slot.valid && (!w_eol || i_res_ready);
    assign o_res_valid = i_slot.valid && w_eol;
    assign w_byte      = o_take && !w_eol && !r_term && (w_c != CHAR_NUL)
                         && !(r_skipping && f_is_blank(w_c));

    always_comb begin
        w_res.level       = r_header ? r_star[MLC_LEVEL_W-1:0] : '0;
        w_res.bullet_line = r_bullet;
        w_res.number_line = (r_kind == KIND_DIGIT) && (r_phase == NUM_MATCH);
        w_res.is_todo     = (r_position >= PREFIX_LEN) && r_todo;
        w_res.is_done     = !w_res.is_todo && (r_position >= PREFIX_LEN) && r_done;
        w_res.detected    = (w_res.level != '0) || w_res.bullet_line || w_res.number_line
                            || w_res.is_todo || w_res.is_done;
    end

    assign o_res = w_res;

    always_comb begin
        n_skipping = r_skipping;
        n_position = r_position;
        n_star     = r_star;
        n_header   = r_header;
        n_kind     = r_kind;
        n_todo     = r_todo;
        n_done     = r_done;
        n_phase    = r_phase;
        n_bullet   = r_bullet;
        n_term     = r_term;

        if (o_take && w_eol) begin
            n_skipping = 1'b1;
            n_position = '0;
            n_star     = '0;
            n_header   = 1'b0;
            n_kind     = KIND_NONE;
            n_todo     = 1'b1;
            n_done     = 1'b1;
            n_phase    = NUM_DIGITS;
            n_bullet   = 1'b0;
            n_term     = 1'b0;
        end else if (o_take && !r_term && (w_c == CHAR_NUL)) begin
            n_term = 1'b1;
        end else if (w_byte) begin
            n_skipping = 1'b0;

            if ((r_position == r_star) && (r_star < STAR_SAT)) begin
                if (w_c == CHAR_STAR) begin
                    n_star = r_star + 3'd1;
                end else if ((r_star != '0) && f_is_blank(w_c)) begin
                    n_header = 1'b1;
                end
            end

            if (r_position < PREFIX_LEN) begin
                if (w_c != f_todo_char(r_position)) n_todo = 1'b0;
                if (w_c != f_done_char(r_position)) n_done = 1'b0;
            end

            if (r_position == '0) begin
                if ((w_c == CHAR_MINUS) || (w_c == CHAR_PLUS) || (w_c == CHAR_STAR)) begin
                    n_kind = KIND_BULLET;
                end else if (f_is_digit(w_c)) begin
                    n_kind = KIND_DIGIT;
                end else begin
                    n_kind = KIND_OTHER;
                end
            end else begin
                if ((r_position == 3'd1) && (r_kind == KIND_BULLET) && (w_c == CHAR_SPACE)) begin
                    n_bullet = 1'b1;
                end
                if (r_kind == KIND_DIGIT) begin
                    if (r_phase == NUM_DIGITS) begin
                        if (f_is_digit(w_c)) begin
                            n_phase = NUM_DIGITS;
                        end else if ((w_c == CHAR_DOT) || (w_c == CHAR_RPAREN)) begin
                            n_phase = NUM_PUNCT;
                        end else begin
                            n_phase = NUM_FAIL;
                        end
                    end else if (r_phase == NUM_PUNCT) begin
                        n_phase = (w_c == CHAR_SPACE) ? NUM_MATCH : NUM_FAIL;
                    end
                end
            end

            if (r_position < POS_MAX) n_position = r_position + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skipping <= 1'b1;
            r_position <= '0;
            r_star     <= '0;
            r_header   <= 1'b0;
            r_kind     <= KIND_NONE;
            r_todo     <= 1'b1;
            r_done     <= 1'b1;
            r_phase    <= NUM_DIGITS;
            r_bullet   <= 1'b0;
            r_term     <= 1'b0;
        end else begin
            r_skipping <= n_skipping;
            r_position <= n_position;
            r_star     <= n_star;
            r_header   <= n_header;
            r_kind     <= n_kind;
            r_todo     <= n_todo;
            r_done     <= n_done;
            r_phase    <= n_phase;
            r_bullet   <= n_bullet;
            r_term     <= n_term;
        end
    end
endmodule

FILE: hdl/mlc_out_stage.sv
module mlc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  mlc_pkg::t_result i_res,
    output logic             o_res_ready,
    mlc_out_if.source        o_out
);
    import mlc_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    w_load;

    assign o_res_ready = !r_valid || o_out.ready;
    assign w_load      = i_res_valid && o_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.level       = r_res.level;
    assign o_out.bullet_line = r_res.bullet_line;
    assign o_out.number_line = r_res.number_line;
    assign o_out.is_todo     = r_res.is_todo;
    assign o_out.is_done     = r_res.is_done;
    assign o_out.detected    = r_res.detected;
endmodule

FILE: hdl/markup_line_classifier_top.sv
// channel | dir | payload                                                  | transfer
// i_in    | in  | ch[7:0], end_of_line                                     | valid & ready
// o_out   | out | level[1:0], bullet_line, number_line, is_todo, is_done,  | valid & ready
//         |     | detected                                                 |
//
// One byte per cycle sustained while no end-of-line item waits on the output side; a byte
// passes the input register and the scan logic, and an end of line loads the result
// register when the scan logic takes it from the input register.
// Synchronous active-low reset clears the line state, so a new line starts scanning.
// An end-of-line item waits in the input register while the result register is full
// and not taken; text bytes never wait on the output side.
`include "assert_macros.svh"

module markup_line_classifier_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlc_in_if.sink    i_in,
    mlc_out_if.source o_out
);
    import mlc_pkg::*;

    t_in_slot w_slot;
    t_result  w_res;
    logic     w_take;
    logic     w_res_valid;
    logic     w_res_ready;
    logic     w_out_any;
    logic     w_byte_take;
    logic     w_out_free;

    mlc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_slot  (w_slot)
    );

    mlc_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slot      (w_slot),
        .i_res_ready (w_res_ready),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mlc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_out       (o_out)
    );

    assign w_out_any   = (o_out.level != '0) || o_out.bullet_line || o_out.number_line
                         || o_out.is_todo || o_out.is_done;
    assign w_byte_take = w_take && !w_slot.item.end_of_line;
    assign w_out_free  = !o_out.valid || o_out.ready;

    `ASSERT_SAME(a_detected_sum, i_clk, i_rst_n, o_out.valid, o_out.detected == w_out_any)
    `ASSERT_SAME(a_todo_done_excl, i_clk, i_rst_n, o_out.valid, !(o_out.is_todo && o_out.is_done))
    `ASSERT_NEXT(a_byte_no_result, i_clk, i_rst_n, w_byte_take && w_out_free, !o_out.valid)
    `ASSERT_NEXT(a_eol_gives_result, i_clk, i_rst_n, w_take && w_slot.item.end_of_line, o_out.valid)

endmodule
